FILE: src/swmd_pkg.sv
// ----------------------------------------------------------------------------
// Sync word measurement deframer package
// Shared constants and the result record used by the deframer modules.
// ----------------------------------------------------------------------------
package swmd_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned ReadingW = 16;
	localparam int unsigned CountW   = 32;
	localparam int unsigned IndexW   = 3;
	localparam int unsigned WindowW  = 24;
	localparam int unsigned ShiftW   = 56;
	localparam int unsigned TdataW   = 2 * ReadingW + CountW;
	localparam int unsigned TuserW   = 2;

	localparam logic [WindowW-1:0]  SYNC_PREFIX  = 24'h524149;
	localparam logic [ByteW-1:0]    SYNC_LAST    = 8'h4C;
	localparam logic [ReadingW-1:0] BAD_MARKER   = 16'h0ABC;
	localparam logic [IndexW-1:0]   PAYLOAD_LAST = 3'd7;

	typedef struct packed {
		logic                       horizontal_valid;
		logic                       vertical_valid;
		logic signed [CountW-1:0]   path_count;
		logic signed [ReadingW-1:0] horizontal_reading;
		logic signed [ReadingW-1:0] vertical_reading;
	} result_t;

endpackage

FILE: src/sync_word_measurement_deframer_unit.sv
// ----------------------------------------------------------------------------
// Sync word measurement deframer
// Finds the sync word in a byte stream and decodes the eight-byte payload.
// ----------------------------------------------------------------------------
// The result is registered and is valid in the cycle after the last payload byte's transaction.
// Throughput: one byte per cycle; the output register is the only stall point.
// A result is produced for every twelfth byte at best (sync word plus payload).
// Reset clears the sync window, the frame state and the output valid flag.
module sync_word_measurement_deframer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [swmd_pkg::ByteW-1:0]   s_axis_tdata,  // [7:0] rx_byte
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [15:0] vertical_reading, [31:16] horizontal_reading, [63:32] path_count
	output logic [swmd_pkg::TdataW-1:0]  m_axis_tdata,
	// [0] vertical_valid, [1] horizontal_valid
	output logic [swmd_pkg::TuserW-1:0]  m_axis_tuser
);
	import swmd_pkg::*;

	logic    byte_en;
	logic    res_en;
	logic    space;
	result_t res;
	result_t out_res;

	assign s_axis_tready = space;
	assign byte_en       = s_axis_tvalid && space;

	swmd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (byte_en),
		.rx_byte (s_axis_tdata),
		.res_en  (res_en),
		.res     (res)
	);

	swmd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_en),
		.res       (res),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.path_count, out_res.horizontal_reading,
		out_res.vertical_reading};
	assign m_axis_tuser = {out_res.horizontal_valid, out_res.vertical_valid};

endmodule

FILE: src/swmd_parser.sv
// ----------------------------------------------------------------------------
// Sync word measurement deframer parser
// Hunts for the sync word, collects the payload and decodes one frame.
// ----------------------------------------------------------------------------
module swmd_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_en,
	input  logic [swmd_pkg::ByteW-1:0]      rx_byte,
	output logic                            res_en,
	output swmd_pkg::result_t               res
);
	import swmd_pkg::*;

	logic [WindowW-1:0] window_q;
	logic               in_frame_q;
	logic [IndexW-1:0]  index_q;
	logic [ShiftW-1:0]  shift_q;
	logic               sync_hit;
	logic               frame_done;

	assign sync_hit   = !in_frame_q && (window_q == SYNC_PREFIX) && (rx_byte == SYNC_LAST);
	assign frame_done = in_frame_q && (index_q == PAYLOAD_LAST);
	assign res_en     = byte_en && frame_done;

	always_comb begin
		res.vertical_reading   = shift_q[55:40];
		res.horizontal_reading = shift_q[39:24];
		res.path_count         = {shift_q[23:0], rx_byte};
		res.vertical_valid     = (shift_q[55:40] != BAD_MARKER);
		res.horizontal_valid   = (shift_q[39:24] != BAD_MARKER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			in_frame_q <= 1'b0;
			index_q    <= '0;
		end else if (byte_en) begin
			if (!in_frame_q) begin
				if (sync_hit) begin
					in_frame_q <= 1'b1;
					index_q    <= '0;
					window_q   <= '0;
				end else begin
					window_q <= {window_q[WindowW-ByteW-1:0], rx_byte};
				end
			end else if (frame_done) begin
				in_frame_q <= 1'b0;
				index_q    <= '0;
				window_q   <= '0;
			end else begin
				index_q <= index_q + IndexW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en && in_frame_q && !frame_done) begin
			shift_q <= {shift_q[ShiftW-ByteW-1:0], rx_byte};
		end
	end

endmodule

FILE: src/swmd_out_reg.sv
// ----------------------------------------------------------------------------
// Sync word measurement deframer output register
// Holds one decoded result until the downstream side takes it.
// ----------------------------------------------------------------------------
module swmd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  swmd_pkg::result_t res,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output swmd_pkg::result_t out_res
);
	import swmd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			res_q <= res;
		end
	end

endmodule

FILE: src/swmd_checker.sv
// ----------------------------------------------------------------------------
// Sync word measurement deframer checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module swmd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [swmd_pkg::TdataW-1:0]  m_axis_tdata,
	input logic [swmd_pkg::TuserW-1:0]  m_axis_tuser
);
	import swmd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("Stalled output transaction changed.");

	a_vflag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[0] == (m_axis_tdata[15:0] != BAD_MARKER))
		else $error("Vertical valid flag does not match the reading.");

	a_hflag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[1] == (m_axis_tdata[31:16] != BAD_MARKER))
		else $error("Horizontal valid flag does not match the reading.");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("Input ready does not follow the output register state.");

	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> !(m_axis_tvalid && !$past(s_axis_tvalid)))
		else $error("Result appeared without an input transaction.");

endmodule

bind sync_word_measurement_deframer_unit swmd_checker u_swmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
